[rtl/dsma_pkg.sv]
// Types, codes and BCD digit functions shared by the decimal sign-magnitude ALU.
package dsma_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int WIDE_DIGITS = MAX_DIGITS + 1;
    localparam int WIDE_W      = 4 * WIDE_DIGITS;
    localparam int ACC_W       = 8 * MAX_DIGITS;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    typedef logic [WIDE_W-1:0] dsma_wide_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] a_digits;
        logic        a_negative;
        logic [63:0] b_digits;
        logic        b_negative;
    } dsma_op_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic        result_negative;
        logic        divide_by_zero;
    } dsma_res_t;

    typedef struct packed {
        logic [1:0]       action;
        logic             a_neg;
        logic             b_neg;
        logic             b_zero;
        dsma_wide_t       a;
        dsma_wide_t       b;
        dsma_wide_t       b2;
        dsma_wide_t       b4;
        dsma_wide_t       b8;
        dsma_wide_t       sum_as;
        dsma_wide_t       diff;
        logic             ge;
        logic [63:0]      low_as;
        logic             neg_as;
        dsma_wide_t       pp;
        dsma_wide_t       rem;
        logic [ACC_W-1:0] acc;
        logic [63:0]      quo;
    } dsma_stage_t;

    function automatic logic [3:0] digit_clamp(input logic [3:0] d);
        return (d > 4'd9) ? 4'd9 : d;
    endfunction

    function automatic logic [WIDE_W:0] bcd_add(input dsma_wide_t x, input dsma_wide_t y,
                                                 input logic cin);
        logic       c;
        logic [4:0] t;
        dsma_wide_t s;
        c = cin;
        s = '0;
        for (int i = 0; i < WIDE_DIGITS; i++)
        begin
            t = {1'b0, x[4*i +: 4]} + {1'b0, y[4*i +: 4]} + {4'b0, c};
            if (t > 5'd9)
            begin
                t = t + 5'd6;
                c = 1'b1;
            end
            else
            begin
                c = 1'b0;
            end
            s[4*i +: 4] = t[3:0];
        end
        return {c, s};
    endfunction

    function automatic dsma_wide_t bcd_nines(input dsma_wide_t x);
        dsma_wide_t s;
        s = '0;
        for (int i = 0; i < WIDE_DIGITS; i++)
        begin
            s[4*i +: 4] = 4'd9 - x[4*i +: 4];
        end
        return s;
    endfunction

    // top bit set when x >= y
    function automatic logic [WIDE_W:0] bcd_sub(input dsma_wide_t x, input dsma_wide_t y);
        return bcd_add(x, bcd_nines(y), 1'b1);
    endfunction

    function automatic dsma_wide_t bcd_double(input dsma_wide_t x);
        logic       c;
        logic       nc;
        logic [4:0] t;
        dsma_wide_t s;
        c = 1'b0;
        s = '0;
        for (int i = 0; i < WIDE_DIGITS; i++)
        begin
            t = {x[4*i +: 4], 1'b0};
            if (x[4*i +: 4] > 4'd4)
            begin
                t  = t - 5'd10;
                nc = 1'b1;
            end
            else
            begin
                nc = 1'b0;
            end
            s[4*i +: 4] = t[3:0] + {3'b0, c};
            c = nc;
        end
        return s;
    endfunction

    // {tens, ones} of the product of two digits
    function automatic logic [7:0] digit_mul(input logic [3:0] x, input logic [3:0] y);
        logic [6:0] p;
        logic [3:0] tn;
        p  = {3'b0, x} * {3'b0, y};
        tn = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (p >= 7'(10 * k))
            begin
                tn = 4'(k);
            end
        end
        return {tn, 4'(p - ({3'b0, tn} * 7'd10))};
    endfunction

endpackage

[rtl/dsma_prep.sv]
// Front stages: digit clamping, sum and difference, sign rules and divisor multiples.
module dsma_prep #(
    parameter int DIGITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  dsma_pkg::dsma_op_t    in_data,
    output logic                  out_valid,
    output dsma_pkg::dsma_stage_t out_data
);

    localparam int DW = 4 * DIGITS;
    localparam dsma_pkg::dsma_wide_t NMASK =
        (dsma_pkg::dsma_wide_t'(1) << DW) - dsma_pkg::dsma_wide_t'(1);

    dsma_pkg::dsma_wide_t  a_s;
    dsma_pkg::dsma_wide_t  b_s;
    logic [dsma_pkg::WIDE_W:0] sum_w;
    logic [dsma_pkg::WIDE_W:0] dif_w;
    logic [dsma_pkg::WIDE_W:0] neg_w;
    dsma_pkg::dsma_wide_t  low_w;
    logic                  same;
    logic                  do_sum;
    logic                  a_big;

    dsma_pkg::dsma_stage_t s1_next;
    dsma_pkg::dsma_stage_t s1_reg;
    logic                  v1_reg;
    dsma_pkg::dsma_stage_t s2_next;
    dsma_pkg::dsma_stage_t s2_reg;
    logic                  v2_reg;

    always_comb
    begin
        a_s = '0;
        b_s = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            a_s[4*i +: 4] = dsma_pkg::digit_clamp(in_data.a_digits[4*i +: 4]);
            b_s[4*i +: 4] = dsma_pkg::digit_clamp(in_data.b_digits[4*i +: 4]);
        end
        sum_w = dsma_pkg::bcd_add(a_s, b_s, 1'b0);
        dif_w = dsma_pkg::bcd_sub(a_s, b_s);
        s1_next        = '0;
        s1_next.action = in_data.action;
        s1_next.a_neg  = in_data.a_negative;
        s1_next.b_neg  = in_data.b_negative;
        s1_next.b_zero = (b_s == '0);
        s1_next.a      = a_s;
        s1_next.b      = b_s;
        s1_next.b2     = dsma_pkg::bcd_double(b_s);
        s1_next.sum_as = sum_w[dsma_pkg::WIDE_W-1:0] & NMASK;
        s1_next.diff   = dif_w[dsma_pkg::WIDE_W-1:0];
        s1_next.ge     = dif_w[dsma_pkg::WIDE_W];
    end

    always_comb
    begin
        same   = (s1_reg.a_neg == s1_reg.b_neg);
        do_sum = (s1_reg.action == dsma_pkg::ACT_ADD) ? same : !same;
        a_big  = s1_reg.ge && (s1_reg.diff != '0);
        neg_w  = dsma_pkg::bcd_sub('0, s1_reg.diff);
        if (do_sum)
        begin
            low_w = s1_reg.sum_as;
        end
        else if (a_big)
        begin
            low_w = s1_reg.diff & NMASK;
        end
        else
        begin
            low_w = neg_w[dsma_pkg::WIDE_W-1:0] & NMASK;
        end
        s2_next        = s1_reg;
        s2_next.b4     = dsma_pkg::bcd_double(s1_reg.b2);
        s2_next.b8     = dsma_pkg::bcd_double(dsma_pkg::bcd_double(s1_reg.b2));
        s2_next.low_as = low_w[63:0];
        s2_next.neg_as = (do_sum || a_big) ? s1_reg.a_neg : !s1_reg.a_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = s2_reg;

endmodule

[rtl/dsma_step.sv]
// A divide trial subtract and, below step 2*DIGITS, a multiply partial product or accumulate.
module dsma_step #(
    parameter int DIGITS = 16,
    parameter int STEP   = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  dsma_pkg::dsma_stage_t in_data,
    output logic                  out_valid,
    output dsma_pkg::dsma_stage_t out_data
);

    localparam int K  = STEP / 2;
    localparam int DK = STEP / 4;
    localparam int DJ = STEP % 4;
    localparam int P  = DIGITS - 1 - DK;

    dsma_pkg::dsma_wide_t      mul_pp;
    logic [dsma_pkg::ACC_W-1:0] mul_acc;
    dsma_pkg::dsma_wide_t      r;
    dsma_pkg::dsma_wide_t      m;
    logic [dsma_pkg::WIDE_W:0] t;
    dsma_pkg::dsma_stage_t     d_next;
    dsma_pkg::dsma_stage_t     d_reg;
    logic                      v_reg;

    generate
        if (STEP < 2 * DIGITS && STEP % 2 == 0)
        begin : g_pp
            dsma_pkg::dsma_wide_t      lo;
            dsma_pkg::dsma_wide_t      hi;
            logic [7:0]                dm;
            logic [dsma_pkg::WIDE_W:0] pp_w;
            always_comb
            begin
                lo = '0;
                hi = '0;
                dm = '0;
                for (int i = 0; i < DIGITS; i++)
                begin
                    dm               = dsma_pkg::digit_mul(in_data.a[4*i +: 4],
                                                           in_data.b[4*K +: 4]);
                    lo[4*i +: 4]     = dm[3:0];
                    hi[4*i + 4 +: 4] = dm[7:4];
                end
                pp_w    = dsma_pkg::bcd_add(lo, hi, 1'b0);
                mul_pp  = pp_w[dsma_pkg::WIDE_W-1:0];
                mul_acc = in_data.acc;
            end
        end
        else if (STEP < 2 * DIGITS)
        begin : g_acc
            logic [dsma_pkg::WIDE_W:0] acc_w;
            always_comb
            begin
                acc_w   = dsma_pkg::bcd_add(in_data.acc[4*K +: dsma_pkg::WIDE_W],
                                            in_data.pp, 1'b0);
                mul_pp  = in_data.pp;
                mul_acc = in_data.acc;
                mul_acc[4*K +: dsma_pkg::WIDE_W] = acc_w[dsma_pkg::WIDE_W-1:0];
            end
        end
        else
        begin : g_idle
            assign mul_pp  = in_data.pp;
            assign mul_acc = in_data.acc;
        end
    endgenerate

    always_comb
    begin
        r = in_data.rem;
        if (DJ == 0)
        begin
            r = {in_data.rem[dsma_pkg::WIDE_W-5:0], in_data.a[4*P +: 4]};
        end
        case (DJ)
            0:       m = in_data.b8;
            1:       m = in_data.b4;
            2:       m = in_data.b2;
            default: m = in_data.b;
        endcase
        t = dsma_pkg::bcd_sub(r, m);
        d_next     = in_data;
        d_next.pp  = mul_pp;
        d_next.acc = mul_acc;
        d_next.rem = t[dsma_pkg::WIDE_W] ? t[dsma_pkg::WIDE_W-1:0] : r;
        d_next.quo[4*P + 3 - DJ] = t[dsma_pkg::WIDE_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

[rtl/dsma_out.sv]
// Result selection, output register and skid stage.
module dsma_out #(
    parameter int DIGITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pipe_valid,
    input  dsma_pkg::dsma_stage_t pipe_data,
    output logic                  en,
    output logic                  res_valid,
    input  logic                  res_stall,
    output dsma_pkg::dsma_res_t   res_data
);

    localparam int DW = 4 * DIGITS;

    dsma_pkg::dsma_res_t res_w;
    logic                push;
    logic                slot;
    logic                out_valid_reg;
    logic                out_valid_next;
    dsma_pkg::dsma_res_t out_data_reg;
    dsma_pkg::dsma_res_t out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    dsma_pkg::dsma_res_t skid_data_reg;
    dsma_pkg::dsma_res_t skid_data_next;

    always_comb
    begin
        res_w = '0;
        case (pipe_data.action)
            dsma_pkg::ACT_ADD, dsma_pkg::ACT_SUB:
            begin
                res_w.result_low      = pipe_data.low_as;
                res_w.result_negative = pipe_data.neg_as;
            end
            dsma_pkg::ACT_MUL:
            begin
                res_w.result_low      = pipe_data.acc[63:0] &
                                        ((64'(1) << DW) - 64'(1));
                res_w.result_high     = 64'(pipe_data.acc >> DW);
                res_w.result_negative = pipe_data.a_neg ^ pipe_data.b_neg;
            end
            dsma_pkg::ACT_DIV:
            begin
                if (pipe_data.b_zero)
                begin
                    res_w.divide_by_zero = 1'b1;
                end
                else
                begin
                    res_w.result_low      = pipe_data.quo;
                    res_w.result_negative = pipe_data.a_neg ^ pipe_data.b_neg;
                end
            end
            default:
            begin
                res_w = '0;
            end
        endcase
    end

    assign en   = !skid_valid_reg;
    assign push = en && pipe_valid;
    assign slot = !out_valid_reg || !res_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg && res_stall;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (slot)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_w;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

[rtl/decimal_sign_magnitude_alu_core.sv]
// Top level of the pipelined decimal sign-magnitude ALU.
//
// A request on the op channel carries an action (add, subtract, multiply,
// divide) and two sign-magnitude operands of DIGITS BCD digits. It is taken
// at a rising edge where op_valid is high and op_stall is low. Each request
// gives exactly one result on the res channel, taken where res_valid is high
// and res_stall is low; results leave in request order.
// From acceptance to res_valid a request passes two front stages, then
// 4*DIGITS steps set by the divider, which tries one quotient bit per step;
// the multiplier shares the same steps. The output register follows.
// Throughput is one request per cycle while op_stall is low.
// When the receiver stalls, the waiting result holds in the output register
// and one more result drops into a skid stage; the whole pipeline then holds
// and op_stall rises until the skid stage drains.
// Reset clears all valid bits; op_stall is low out of reset.
module decimal_sign_magnitude_alu_core #(
    parameter int DIGITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_stall,
    input  dsma_pkg::dsma_op_t  op_data,
    output logic                res_valid,
    input  logic                res_stall,
    output dsma_pkg::dsma_res_t res_data
);

    localparam int NS = 4 * DIGITS;

    logic                  en;
    logic                  v [0:NS];
    dsma_pkg::dsma_stage_t d [0:NS];

    assign op_stall = !en;

    dsma_prep #(
        .DIGITS(DIGITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (op_valid),
        .in_data   (op_data),
        .out_valid (v[0]),
        .out_data  (d[0])
    );

    generate
        for (genvar s = 0; s < NS; s++)
        begin : g_step
            dsma_step #(
                .DIGITS(DIGITS),
                .STEP  (s)
            ) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (v[s]),
                .in_data   (d[s]),
                .out_valid (v[s+1]),
                .out_data  (d[s+1])
            );
        end
    endgenerate

    dsma_out #(
        .DIGITS(DIGITS)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (v[NS]),
        .pipe_data  (d[NS]),
        .en         (en),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

[rtl/dsma_checker.sv]
// Port-level checks for the decimal sign-magnitude ALU, bound to the top level.
module dsma_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                op_valid,
    input logic                op_stall,
    input dsma_pkg::dsma_op_t  op_data,
    input logic                res_valid,
    input logic                res_stall,
    input dsma_pkg::dsma_res_t res_data
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.divide_by_zero |->
            res_data.result_low == 64'd0 && res_data.result_high == 64'd0 &&
            !res_data.result_negative)
        else $error("zero-divisor result not cleared");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(op_stall) |-> $past(res_valid && res_stall))
        else $error("request stall without a held result");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |-> res_valid)
        else $error("request stall with an empty output");

endmodule

bind decimal_sign_magnitude_alu_core dsma_checker u_dsma_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the decimal sign-magnitude ALU core.
module testbench;

    localparam int N_DIGITS    = 16;
    localparam int LATENCY     = 4 * N_DIGITS + 3;
    localparam int RANDOM_OPS  = 1750;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n;
    logic                op_valid;
    logic                op_stall;
    dsma_pkg::dsma_op_t  op_data;
    logic                res_valid;
    logic                res_stall;
    dsma_pkg::dsma_res_t res_data;

    dsma_pkg::dsma_res_t expected_results[$];
    int        errors;
    int        cycles;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        drained;

    typedef struct {
        dsma_pkg::dsma_op_t  op;
        bit                  typed;
        dsma_pkg::dsma_res_t res;
    } stim_row_t;

    stim_row_t directed_rows[$];

    decimal_sign_magnitude_alu_core #(.DIGITS(N_DIGITS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .op_valid(op_valid),
        .op_stall(op_stall),
        .op_data(op_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data(res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic logic [127:0] bcd_value(input logic [63:0] bcd);
        logic [127:0] v;
        logic [3:0]   d;
        v = '0;
        for (int i = N_DIGITS - 1; i >= 0; i--)
        begin
            d = bcd[4*i +: 4];
            if (d > 4'd9)
                d = 4'd9;
            v = v * 10 + d;
        end
        return v;
    endfunction

    function automatic logic [127:0] value_bcd(input logic [127:0] v, input int n);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
        begin
            r[4*i +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return r;
    endfunction

    function automatic dsma_pkg::dsma_res_t compute_result(input dsma_pkg::dsma_op_t op);
        dsma_pkg::dsma_res_t r;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] m;
        logic [127:0] p;
        logic         same;
        logic         add_mags;
        logic         a_big;
        r = '0;
        a = bcd_value(op.a_digits);
        b = bcd_value(op.b_digits);
        m = 1;
        for (int i = 0; i < N_DIGITS; i++)
            m = m * 10;
        case (op.action)
            dsma_pkg::ACT_ADD, dsma_pkg::ACT_SUB:
            begin
                same     = (op.a_negative == op.b_negative);
                add_mags = (op.action == dsma_pkg::ACT_ADD) ? same : !same;
                a_big    = a > b;
                if (add_mags)
                begin
                    p = (a + b) % m;
                    r.result_negative = op.a_negative;
                end
                else
                begin
                    p = a_big ? a - b : b - a;
                    if (op.action == dsma_pkg::ACT_ADD)
                        r.result_negative = a_big ? op.a_negative : op.b_negative;
                    else if (!op.a_negative)
                        r.result_negative = !a_big;
                    else
                        r.result_negative = a_big;
                end
                r.result_low = 64'(value_bcd(p, N_DIGITS));
            end
            dsma_pkg::ACT_MUL:
            begin
                p = value_bcd(a * b, 2 * N_DIGITS);
                r.result_low      = p[63:0];
                r.result_high     = p[127:64];
                r.result_negative = op.a_negative ^ op.b_negative;
            end
            default:
            begin
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                begin
                    r.result_low      = 64'(value_bcd(a / b, N_DIGITS));
                    r.result_negative = op.a_negative ^ op.b_negative;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] random_bcd();
        logic [63:0] v;
        int          len;
        v   = '0;
        len = $urandom_range(N_DIGITS, 1);
        for (int i = 0; i < len; i++)
            v[4*i +: 4] = 4'($urandom_range(9, 0));
        if ($urandom_range(15, 0) == 0)
            v = {$urandom, $urandom};
        return v;
    endfunction

    function automatic dsma_pkg::dsma_op_t random_op();
        dsma_pkg::dsma_op_t op;
        op.action     = 2'($urandom_range(3, 0));
        op.a_digits   = random_bcd();
        op.a_negative = 1'($urandom);
        op.b_digits   = ($urandom_range(19, 0) == 0) ? 64'h0 : random_bcd();
        op.b_negative = 1'($urandom);
        if ($urandom_range(9, 0) == 0)
            op.b_digits = op.a_digits;
        return op;
    endfunction

    function automatic void add_row(input logic [1:0] act, input logic [63:0] a,
                                    input logic an, input logic [63:0] b, input logic bn,
                                    input bit typed, input logic [63:0] lo,
                                    input logic [63:0] hi, input logic neg, input logic dz);
        stim_row_t row;
        row.op       = '{action: act, a_digits: a, a_negative: an,
                         b_digits: b, b_negative: bn};
        row.typed    = typed;
        row.res      = '{result_low: lo, result_high: hi,
                         result_negative: neg, divide_by_zero: dz};
        directed_rows.push_back(row);
    endfunction

    task automatic send_op(input dsma_pkg::dsma_op_t op, input dsma_pkg::dsma_res_t exp_res);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            op_valid <= 1'b0;
            @(negedge clk);
        end
        op_valid <= 1'b1;
        op_data  <= op;
        @(posedge clk);
        while (op_stall)
            @(posedge clk);
        expected_results.push_back(exp_res);
        @(negedge clk);
    endtask

    always @(negedge clk)
        res_stall <= rst_n && ($urandom_range(99, 0) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %h", res_data);
                errors++;
            end
            else
            begin
                dsma_pkg::dsma_res_t e;
                e = expected_results.pop_front();
                if (res_data.result_low !== e.result_low)
                begin
                    $error("result_low expected %h actual %h", e.result_low,
                           res_data.result_low);
                    errors++;
                end
                if (res_data.result_high !== e.result_high)
                begin
                    $error("result_high expected %h actual %h", e.result_high,
                           res_data.result_high);
                    errors++;
                end
                if (res_data.result_negative !== e.result_negative)
                begin
                    $error("result_negative expected %b actual %b", e.result_negative,
                           res_data.result_negative);
                    errors++;
                end
                if (res_data.divide_by_zero !== e.divide_by_zero)
                begin
                    $error("divide_by_zero expected %b actual %b", e.divide_by_zero,
                           res_data.divide_by_zero);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        dsma_pkg::dsma_res_t exp_res;
        errors         = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        op_valid       = 1'b0;
        op_data        = '0;
        res_stall      = 1'b0;

        // sign rules, extremes, clamping, zero divisor
        add_row(dsma_pkg::ACT_ADD, 64'h1, 0, 64'h2, 0, 1, 64'h3, 64'h0, 0, 0);
        add_row(dsma_pkg::ACT_ADD, {16{4'h9}}, 0, 64'h1, 0, 1, 64'h0, 64'h0, 0, 0);
        add_row(dsma_pkg::ACT_ADD, 64'h5, 0, 64'h5, 1, 1, 64'h0, 64'h0, 1, 0);
        add_row(dsma_pkg::ACT_ADD, 64'h7, 1, 64'h3, 0, 0, '0, '0, 0, 0);
        add_row(dsma_pkg::ACT_ADD, 64'h3, 1, 64'h7, 0, 0, '0, '0, 0, 0);
        add_row(dsma_pkg::ACT_SUB, 64'h4, 0, 64'h4, 0, 1, 64'h0, 64'h0, 1, 0);
        add_row(dsma_pkg::ACT_SUB, 64'h9, 0, 64'h2, 0, 0, '0, '0, 0, 0);
        add_row(dsma_pkg::ACT_SUB, 64'h9, 1, 64'h2, 1, 0, '0, '0, 0, 0);
        add_row(dsma_pkg::ACT_SUB, 64'h2, 1, 64'h9, 1, 0, '0, '0, 0, 0);
        add_row(dsma_pkg::ACT_SUB, 64'h2, 0, 64'h9, 1, 0, '0, '0, 0, 0);
        add_row(dsma_pkg::ACT_MUL, {16{4'h9}}, 0, {16{4'h9}}, 1, 1, {{15{4'h0}}, 4'h1},
                {{4'h9}, {14{4'h9}}, 4'h8}, 1, 0);
        add_row(dsma_pkg::ACT_MUL, 64'h0, 1, 64'h123, 0, 1, 64'h0, 64'h0, 1, 0);
        add_row(dsma_pkg::ACT_MUL, {16{4'hF}}, 0, 64'h2, 0, 0, '0, '0, 0, 0);
        add_row(dsma_pkg::ACT_DIV, 64'h10, 0, 64'h0, 1, 1, 64'h0, 64'h0, 0, 1);
        add_row(dsma_pkg::ACT_DIV, {16{4'hF}}, 1, {16{4'h0}}, 0, 1, 64'h0, 64'h0, 0, 1);
        add_row(dsma_pkg::ACT_DIV, 64'h3, 1, 64'h7, 0, 1, 64'h0, 64'h0, 1, 0);
        add_row(dsma_pkg::ACT_DIV, {16{4'h9}}, 0, 64'h1, 1, 1, {16{4'h9}}, 64'h0, 1, 0);
        add_row(dsma_pkg::ACT_DIV, 64'h100, 0, 64'h7, 0, 0, '0, '0, 0, 0);
        add_row(dsma_pkg::ACT_ADD, {16{4'hA}}, 1, {16{4'hF}}, 1, 0, '0, '0, 0, 0);
        add_row(dsma_pkg::ACT_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0, 1, 0, '0, '0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            exp_res = directed_rows[i].typed ? directed_rows[i].res
                                             : compute_result(directed_rows[i].op);
            send_op(directed_rows[i].op, exp_res);
        end

        for (int k = 0; k < RANDOM_OPS; k++)
        begin
            dsma_pkg::dsma_op_t op;
            case ((k * 5) / RANDOM_OPS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (k == RANDOM_OPS / 2)
            begin
                op_valid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            op = random_op();
            send_op(op, compute_result(op));
        end
        op_valid <= 1'b0;

        recv_stall_pct = 0;
        drained = 0;
        while (!drained)
        begin
            @(posedge clk);
            drained = (expected_results.size() == 0);
        end
        repeat (LATENCY + 10) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
